[src/rgsa_pkg.sv]
// Package for the refcounted glyph slot allocator.
// Holds the beat structs, the table entry type, the status codes and sizing constants.
// No dependencies.
`default_nettype none
package rgsa_pkg;

	localparam int SLOTS_DEF = 8;

	localparam logic [3:0] NO_SLOT    = 4'd8;
	localparam logic [7:0] COUNT_FULL = 8'hFF;

	localparam logic [2:0] STAT_REUSED   = 3'd0;
	localparam logic [2:0] STAT_LOADED   = 3'd1;
	localparam logic [2:0] STAT_HELD     = 3'd2;
	localparam logic [2:0] STAT_CFULL    = 3'd3;
	localparam logic [2:0] STAT_TFULL    = 3'd4;
	localparam logic [2:0] STAT_RELEASED = 3'd5;
	localparam logic [2:0] STAT_BADREL   = 3'd6;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] pattern_id;
		logic [39:0] pattern_bits;
		logic [3:0]  held_slot;
	} req_t;

	typedef struct packed {
		logic [3:0] slot;
		logic [2:0] status;
		logic [2:0] row_index;
		logic [4:0] row_data;
		logic       upload;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] pattern_id;
		logic [7:0]  refcount;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[src/rgsa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot table; no dependencies.
`default_nettype none
module rgsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[src/refcounted_glyph_slot_allocator.sv]
// Refcounted glyph slot allocator, top level; uses rgsa_pkg and rgsa_ram.
// Held-slot acquires and out-of-range releases answer from S_IDLE, releases from S_REL, other
// acquires after the S_SCAN sweep; a new glyph's first row, then 7 more beats, come from S_LOAD.
// Throughput: one request at a time; a lookup sweeps the slot RAM one entry per cycle.
// Reset clears the control state and the per-entry written flags at once, so
// unwritten entries read as empty; no clearing pass is needed.
`default_nettype none
module refcounted_glyph_slot_allocator
	import rgsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [4:0]    SLOTS_V = 5'(SLOTS);
	localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);
	localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REL    = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_LOAD   = 3'd4;

	logic [2:0]    state_q;
	logic [15:0]   pid_q;
	logic [39:0]   bits_q;
	logic [SW-1:0] held_q;
	logic [CW-1:0] scan_q;
	logic          chk_s1;
	logic [SW-1:0] idx_s1;
	logic          match_q;
	logic [SW-1:0] match_idx_q;
	logic [7:0]    match_cnt_q;
	logic          free_q;
	logic [SW-1:0] free_idx_q;
	logic [2:0]    row_q;
	logic [SLOTS-1:0] written_q;

	logic          out_valid_q;
	rsp_t          out_q;

	logic          we;
	logic [SW-1:0] waddr;
	entry_t        wdata;
	logic [SW-1:0] raddr;
	logic [ENTRY_W-1:0] rdata_raw;
	entry_t        rd;
	entry_t        cur;
	logic [SW-1:0] cur_idx;

	logic          accept;
	logic          out_free;
	logic          emit;
	rsp_t          emit_rsp;
	logic          held_in_range;

	rgsa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rd = entry_t'(rdata_raw);

	assign req_stall = (state_q != S_IDLE) || out_valid_q;
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign held_in_range = ({1'b0, req.held_slot} < SLOTS_V);
	assign cur_idx = (state_q == S_REL) ? held_q : idx_s1;

	always_comb begin
		cur = rd;
		if (!written_q[cur_idx]) begin
			cur = '0;
		end
	end

	always_comb begin
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req.op == OP_RELEASE) begin
					raddr = req.held_slot[SW-1:0];
				end
			end
			S_REL:  raddr = held_q;
			S_SCAN: raddr = scan_q[SW-1:0];
			default: raddr = '0;
		endcase
	end

	always_comb begin
		emit     = 1'b0;
		emit_rsp = '0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		emit_rsp.slot = NO_SLOT;
		emit_rsp.last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_RELEASE && !held_in_range) begin
						emit            = 1'b1;
						emit_rsp.status = STAT_BADREL;
					end else if (req.op == OP_ACQUIRE && held_in_range) begin
						emit            = 1'b1;
						emit_rsp.slot   = req.held_slot;
						emit_rsp.status = STAT_HELD;
					end
				end
			end
			S_REL: begin
				if (out_free) begin
					emit = 1'b1;
					if (cur.refcount == '0) begin
						emit_rsp.status = STAT_BADREL;
					end else begin
						emit_rsp.status = STAT_RELEASED;
						we             = 1'b1;
						waddr          = held_q;
						wdata          = cur;
						wdata.refcount = cur.refcount - 8'd1;
					end
				end
			end
			S_DECIDE: begin
				if (out_free) begin
					if (match_q) begin
						emit = 1'b1;
						if (match_cnt_q == COUNT_FULL) begin
							emit_rsp.status = STAT_CFULL;
						end else begin
							emit_rsp.status  = STAT_REUSED;
							emit_rsp.slot    = 4'(match_idx_q);
							we               = 1'b1;
							waddr            = match_idx_q;
							wdata.valid      = 1'b1;
							wdata.pattern_id = pid_q;
							wdata.refcount   = match_cnt_q + 8'd1;
						end
					end else if (free_q) begin
						we               = 1'b1;
						waddr            = free_idx_q;
						wdata.valid      = 1'b1;
						wdata.pattern_id = pid_q;
						wdata.refcount   = 8'd1;
					end else begin
						emit            = 1'b1;
						emit_rsp.status = STAT_TFULL;
					end
				end
			end
			S_LOAD: begin
				if (out_free) begin
					emit               = 1'b1;
					emit_rsp.slot      = 4'(free_idx_q);
					emit_rsp.status    = STAT_LOADED;
					emit_rsp.row_index = row_q;
					emit_rsp.row_data  = bits_q[39:35];
					emit_rsp.upload    = 1'b1;
					emit_rsp.last      = (row_q == 3'd7);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			chk_s1      <= 1'b0;
			written_q   <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					chk_s1 <= 1'b0;
					if (accept) begin
						if (req.op == OP_RELEASE) begin
							if (held_in_range) begin
								state_q <= S_REL;
							end
						end else if (!held_in_range) begin
							state_q <= S_SCAN;
							chk_s1  <= 1'b1;
						end
					end
				end
				S_REL: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					chk_s1 <= (scan_q != SCAN_END);
					if (chk_s1 && idx_s1 == LAST_IDX) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						state_q <= (match_q || !free_q) ? S_IDLE : S_LOAD;
					end
				end
				S_LOAD: begin
					if (out_free && row_q == 3'd7) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_rsp;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pid_q   <= req.pattern_id;
					bits_q  <= req.pattern_bits;
					held_q  <= req.held_slot[SW-1:0];
					scan_q  <= CW'(1);
					idx_s1  <= '0;
					match_q <= 1'b0;
					free_q  <= 1'b0;
					row_q   <= '0;
				end
			end
			S_SCAN: begin
				if (scan_q != SCAN_END) begin
					idx_s1 <= scan_q[SW-1:0];
					scan_q <= scan_q + CW'(1);
				end
				if (chk_s1) begin
					if (!match_q && cur.valid && cur.pattern_id == pid_q) begin
						match_q     <= 1'b1;
						match_idx_q <= idx_s1;
						match_cnt_q <= cur.refcount;
					end
					if (!free_q && cur.refcount == '0) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
				end
			end
			S_LOAD: begin
				if (out_free) begin
					row_q  <= row_q + 3'd1;
					bits_q <= {bits_q[34:0], 5'd0};
				end
			end
			default: begin
				row_q <= row_q;
			end
		endcase
	end

endmodule
`default_nettype wire
